@@ hdl/descending_insertion_sorter_assert.svh @@
// Assertion macros for the sorter top-level RTL.
`ifndef DESCENDING_INSERTION_SORTER_ASSERT_SVH
`define DESCENDING_INSERTION_SORTER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define DIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/dis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dis_pkg;

  // Table capacity. It must be a multiple of the read group size.
  localparam int unsigned DEPTH   = 512;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned RANK_W  = 9;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  // The rank read selects within a group first, then between groups.
  localparam int unsigned GRP     = 16;
  localparam int unsigned GRP_W   = $clog2(GRP);
  localparam int unsigned NGRP    = DEPTH / GRP;
  localparam int unsigned NGRP_W  = $clog2(NGRP);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // One stored entry.
  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [INDEX_W-1:0] idx;
  } entry_t;

  // What a cell hands to its right-hand neighbour.
  typedef struct packed {
    logic   occ;  // cell holds an entry
    logic   ge;   // held cost is at least the broadcast key
    entry_t ent;
  } link_t;

endpackage

`default_nettype wire

@@ hdl/dis_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dis_cmd_if;
  import dis_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [COST_W-1:0] cost_value;
  logic [RANK_W-1:0] rank;

  modport source (output valid, command, cost_value, rank, input ready);
  modport sink   (input valid, command, cost_value, rank, output ready);
endinterface

`default_nettype wire

@@ hdl/dis_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dis_res_if;
  import dis_pkg::*;

  logic               valid;
  logic               ready;
  logic [COST_W-1:0]  out_cost;
  logic [INDEX_W-1:0] out_index;
  logic               valid_res;

  modport source (output valid, out_cost, out_index, valid_res, input ready);
  modport sink   (input valid, out_cost, out_index, valid_res, output ready);
endinterface

`default_nettype wire

@@ hdl/descending_insertion_sorter.sv @@
// Insert and clear transactions are never held off and may follow back to back.
// A read transaction reaches the output register through a two-stage registered
// select over the cell row, group registers first; the next read is taken once
// the first select stage is free and the output register is free or emptying.
// Reset (asynchronous, active low) empties the table and clears the output valid;
// no clearing pass is needed, as every cell has its own occupied bit.
`timescale 1ns / 1ps
`default_nettype none

`include "descending_insertion_sorter_assert.svh"

module descending_insertion_sorter (
  input  logic       clk_i,
  input  logic       rst_ni,
  dis_cmd_if.sink    cmd_i,
  dis_res_if.source  res_o
);
  import dis_pkg::*;

  logic               is_read, is_insert, is_clear;
  logic               cmd_acc, insert_go, clear_go, read_go;
  logic [COUNT_W-1:0] entry_count_q, entry_count_d;
  logic               rd1_q, hit1_q;
  logic               out_valid_q, out_valid_d, valid_res_q;
  link_t              links [DEPTH];
  entry_t             ents  [DEPTH];
  entry_t             sel;
  logic [DEPTH-1:0]   occ_vec;
  link_t              head;

  // Command decode.
  always_comb begin
    is_read   = 1'b0;
    is_insert = 1'b0;
    is_clear  = 1'b0;
    case (cmd_e'(cmd_i.command))
      CMD_INSERT: is_insert = 1'b1;
      CMD_READ:   is_read   = 1'b1;
      CMD_CLEAR:  is_clear  = 1'b1;
      default:    ;
    endcase
  end

  // Inserts and clears never wait; a read waits for a free select stage and
  // a free (or emptying) output register.
  assign cmd_i.ready = !is_read || (!rd1_q && (!out_valid_q || res_o.ready));
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign insert_go   = cmd_acc && is_insert && (entry_count_q != COUNT_W'(DEPTH));
  assign clear_go    = cmd_acc && is_clear;
  assign read_go     = cmd_acc && is_read;

  // Entry count, which is also the next arrival number.
  always_comb begin
    entry_count_d = entry_count_q;
    if (clear_go) begin
      entry_count_d = '0;
    end else if (insert_go) begin
      entry_count_d = entry_count_q + COUNT_W'(1);
    end
  end

  // The left end of the row behaves as an occupied cell above any key.
  assign head.occ = 1'b1;
  assign head.ge  = 1'b1;
  assign head.ent = '0;

  // Row of compare-and-shift cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dis_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (clear_go),
      .insert_i  (insert_go),
      .key_i     (cmd_i.cost_value),
      .arrival_i (entry_count_q[INDEX_W-1:0]),
      .prev_i    ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
      .link_o    (links[i])
    );
    assign ents[i]    = links[i].ent;
    assign occ_vec[i] = links[i].occ;
  end

  // Rank select.
  dis_rd_sel u_rd_sel (
    .clk_i  (clk_i),
    .cap1_i (read_go),
    .cap2_i (rd1_q),
    .rank_i (cmd_i.rank),
    .ent_i  (ents),
    .sel_o  (sel)
  );

  // Output valid: set as the select completes, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (rd1_q) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      rd1_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      entry_count_q <= entry_count_d;
      rd1_q         <= read_go;
      out_valid_q   <= out_valid_d;
    end
  end

  // Whether the requested rank is filled, carried alongside the select.
  always_ff @(posedge clk_i) begin
    if (read_go) begin
      hit1_q <= COUNT_W'(cmd_i.rank) < entry_count_q;
    end
    if (rd1_q) begin
      valid_res_q <= hit1_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.valid_res = valid_res_q;
  assign res_o.out_cost  = valid_res_q ? sel.cost : '0;
  assign res_o.out_index = valid_res_q ? sel.idx  : '0;

  // Checks.
  `DIS_ASSERT(a_count_range, entry_count_q <= COUNT_W'(DEPTH), "entry count beyond capacity")
  `DIS_ASSERT(a_occ_matches_count, $countones(occ_vec) == int'(entry_count_q), "occupied cells disagree with entry count")
  `DIS_ASSERT(a_select_lands, rd1_q |=> out_valid_q, "completed read did not reach output")
  `DIS_ASSERT(a_no_read_overrun, rd1_q |-> !read_go, "read accepted while select stage busy")
  `DIS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (entry_count_q == '0) || rst_ni, "table not empty after reset")

endmodule

`default_nettype wire

@@ hdl/dis_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dis_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        insert_i,
  input  logic [dis_pkg::COST_W-1:0]  key_i,
  input  logic [dis_pkg::INDEX_W-1:0] arrival_i,
  input  dis_pkg::link_t              prev_i,
  output dis_pkg::link_t              link_o
);
  import dis_pkg::*;

  logic   occ_q, occ_d;
  entry_t ent_q, ent_d;
  logic   ge_self;

  // The new key goes after every held cost that is greater or equal.
  assign ge_self = occ_q && (ent_q.cost >= key_i);

  // On insert, a cell whose left neighbour is below the key takes the
  // neighbour's entry; the first cell below the key takes the key itself.
  always_comb begin
    occ_d = occ_q;
    ent_d = ent_q;
    if (clear_i) begin
      occ_d = 1'b0;
    end else if (insert_i) begin
      if (!prev_i.ge) begin
        occ_d = prev_i.occ;
        ent_d = prev_i.ent;
      end else if (!ge_self) begin
        occ_d      = 1'b1;
        ent_d.cost = key_i;
        ent_d.idx  = arrival_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Entry payload needs no reset; the occupied bit qualifies it.
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign link_o.occ = occ_q;
  assign link_o.ge  = ge_self;
  assign link_o.ent = ent_q;

endmodule

`default_nettype wire

@@ hdl/dis_rd_sel.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dis_rd_sel (
  input  logic                       clk_i,
  input  logic                       cap1_i,
  input  logic                       cap2_i,
  input  logic [dis_pkg::RANK_W-1:0] rank_i,
  input  dis_pkg::entry_t            ent_i [dis_pkg::DEPTH],
  output dis_pkg::entry_t            sel_o
);
  import dis_pkg::*;

  entry_t            grp_q [NGRP];
  logic [NGRP_W-1:0] gsel_q;
  entry_t            sel_q;

  // First stage: pick the entry within each group by the low rank bits.
  always_ff @(posedge clk_i) begin
    if (cap1_i) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= ent_i[g * GRP + int'(rank_i[GRP_W-1:0])];
      end
      gsel_q <= rank_i[GRP_W +: NGRP_W];
    end
  end

  // Second stage: pick the group by the high rank bits.
  always_ff @(posedge clk_i) begin
    if (cap2_i) begin
      sel_q <= grp_q[gsel_q];
    end
  end

  assign sel_o = sel_q;

endmodule

`default_nettype wire

@@ tb/tb_descending_insertion_sorter.sv @@
`timescale 1ns / 1ps

module tb_descending_insertion_sorter;
  import dis_pkg::*;

  // Command code that the block has to ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [INDEX_W-1:0] idx;
    logic               hit;
  } read_res_t;

  // One command transaction, with a typed-in expectation where it is obvious.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [COST_W-1:0] cost;
    logic [RANK_W-1:0] rank;
    bit                typed;
    read_res_t         want;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  dis_cmd_if cmd_bus ();
  dis_res_if res_bus ();

  descending_insertion_sorter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  // Shadow copy of the sorted table.
  logic [COST_W-1:0]  cost_tbl [DEPTH];
  logic [INDEX_W-1:0] idx_tbl  [DEPTH];
  int unsigned        fill_count = 0;

  cmd_row_t    sent_rows[$];
  read_res_t   pending_reads[$];
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned planned_fill = 0;
  int unsigned work_items   = 0;
  bit          src_calm     = 1'b0;
  bit          sink_calm    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic cmd_row_t mk_row(logic [CMD_W-1:0] command, logic [COST_W-1:0] cost,
                                      logic [RANK_W-1:0] rank);
    cmd_row_t r;
    r = '0;
    r.command = command;
    r.cost    = cost;
    r.rank    = rank;
    return r;
  endfunction

  function automatic cmd_row_t mk_checked(logic [CMD_W-1:0] command, logic [RANK_W-1:0] rank,
                                          logic [COST_W-1:0] ecost, logic [INDEX_W-1:0] eidx,
                                          logic ehit);
    cmd_row_t r;
    r = mk_row(command, '0, rank);
    r.typed = 1'b1;
    r.want  = '{ecost, eidx, ehit};
    return r;
  endfunction

  // Applies one accepted transaction to the shadow table; returns 1 when a
  // read result is due, with that result in res.
  function automatic bit apply_to_table(input cmd_row_t tr, output read_res_t res);
    int unsigned pos;
    res = '0;
    case (tr.command)
      CMD_INSERT: begin
        if (fill_count < DEPTH) begin
          pos = 0;
          // Equal costs stay ahead of the newcomer, so arrival order is kept.
          while (pos < fill_count && tr.cost <= cost_tbl[pos]) pos++;
          for (int unsigned k = fill_count; k > pos; k--) begin
            cost_tbl[k] = cost_tbl[k-1];
            idx_tbl[k]  = idx_tbl[k-1];
          end
          cost_tbl[pos] = tr.cost;
          idx_tbl[pos]  = INDEX_W'(fill_count);
          fill_count++;
        end
      end
      CMD_READ: begin
        if (tr.rank < fill_count) res = '{cost_tbl[tr.rank], idx_tbl[tr.rank], 1'b1};
        return 1'b1;
      end
      CMD_CLEAR: fill_count = 0;
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap(bit calm);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (calm || sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Costs clustered around a few values so that ties are frequent.
  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, 7);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      3:       return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Mostly filled ranks, some just past the end, some anywhere.
  function automatic logic [RANK_W-1:0] pick_rank();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (planned_fill > 0 && sel < 7) return RANK_W'($urandom_range(0, planned_fill - 1));
    if (planned_fill < DEPTH && sel < 9) return RANK_W'(planned_fill);
    return RANK_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic issue(input cmd_row_t tr);
    int gap;
    if (tr.command != CMD_UNUSED && !(tr.command == CMD_INSERT && planned_fill == DEPTH))
      work_items++;
    if (tr.command == CMD_INSERT && planned_fill < DEPTH) planned_fill++;
    if (tr.command == CMD_CLEAR) planned_fill = 0;
    if ($urandom_range(0, 79) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= tr.command;
    cmd_bus.cost_value <= tr.cost;
    cmd_bus.rank       <= tr.rank;
    sent_rows.push_back(tr);
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // A run of inserts with reads mixed in, usually from an empty table.
  task automatic run_episode();
    int n_ins;
    if ($urandom_range(0, 4) != 0) issue(mk_row(CMD_CLEAR, $urandom, RANK_W'($urandom)));
    n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
    repeat (n_ins) begin
      issue(mk_row(CMD_INSERT, pick_cost(), RANK_W'($urandom)));
      if ($urandom_range(0, 5) == 0) issue(mk_row(CMD_READ, $urandom, pick_rank()));
      if ($urandom_range(0, 30) == 0) issue(mk_row(CMD_UNUSED, $urandom, RANK_W'($urandom)));
    end
    repeat ($urandom_range(1, 25)) issue(mk_row(CMD_READ, $urandom, pick_rank()));
  endtask

  // Result sink: random stalls, with calm stretches of constant readiness.
  initial begin
    int stall;
    stall         = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
        stall = pick_gap(sink_calm);
      end
    end
  end

  // Prediction on accepted commands, checking on accepted results, watchdog.
  always @(posedge clk_i) begin
    cmd_row_t  tr;
    read_res_t predicted;
    read_res_t got;
    read_res_t want;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        tr = sent_rows.pop_front();
        if (apply_to_table(tr, predicted)) pending_reads.push_back(tr.typed ? tr.want : predicted);
      end
      if (res_bus.valid && res_bus.ready) begin
        got = '{res_bus.out_cost, res_bus.out_index, res_bus.valid_res};
        if (pending_reads.size() == 0) begin
          note_error($sformatf("unexpected result: cost %h index %0d valid %b",
                               got.cost, got.idx, got.hit));
        end else begin
          want = pending_reads.pop_front();
          if (got.cost !== want.cost || got.idx !== want.idx || got.hit !== want.hit)
            note_error($sformatf("want cost %h index %0d valid %b, got cost %h index %0d valid %b",
                                 want.cost, want.idx, want.hit, got.cost, got.idx, got.hit));
        end
      end
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_descending_insertion_sorter: done, errors");
        $finish;
      end
    end
  end

  initial begin
    cmd_row_t directed[$];

    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = CMD_INSERT;
    cmd_bus.cost_value = '0;
    cmd_bus.rank       = '0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, extreme costs, ties at both ends, an unknown command,
    // out-of-range ranks, and numbering restarting after a clear.
    directed = '{
      mk_checked(CMD_READ, 9'd0,   32'h0, 9'd0, 1'b0),
      mk_checked(CMD_READ, 9'd511, 32'h0, 9'd0, 1'b0),
      mk_row(CMD_INSERT, 32'h0000_0000, 9'd0),
      mk_row(CMD_INSERT, 32'hFFFF_FFFF, 9'd511),
      mk_row(CMD_INSERT, 32'h8000_0000, 9'd0),
      mk_row(CMD_INSERT, 32'hFFFF_FFFF, 9'd0),
      mk_row(CMD_INSERT, 32'h0000_0000, 9'd0),
      mk_checked(CMD_READ, 9'd0,   32'hFFFF_FFFF, 9'd1, 1'b1),
      mk_checked(CMD_READ, 9'd1,   32'hFFFF_FFFF, 9'd3, 1'b1),
      mk_row(CMD_READ, 32'h0, 9'd2),
      mk_row(CMD_READ, 32'h0, 9'd3),
      mk_row(CMD_READ, 32'h0, 9'd4),
      mk_checked(CMD_READ, 9'd5,   32'h0, 9'd0, 1'b0),
      mk_row(CMD_UNUSED, 32'hFFFF_FFFF, 9'd511),
      mk_checked(CMD_READ, 9'd511, 32'h0, 9'd0, 1'b0),
      mk_row(CMD_CLEAR, 32'hFFFF_FFFF, 9'd511),
      mk_checked(CMD_READ, 9'd0,   32'h0, 9'd0, 1'b0),
      mk_row(CMD_INSERT, 32'h5A5A_5A5A, 9'd0),
      mk_checked(CMD_READ, 9'd0,   32'h5A5A_5A5A, 9'd0, 1'b1),
      mk_row(CMD_CLEAR, 32'h0, 9'd0)
    };
    foreach (directed[i]) issue(directed[i]);

    // One pass fills the table to capacity, pushes a few inserts that must be
    // dropped, then reads and clears it; random episodes use up the rest.
    work_items = 0;
    issue(mk_row(CMD_CLEAR, $urandom, RANK_W'($urandom)));
    repeat (DEPTH + 3)
      issue(mk_row(CMD_INSERT,
                   ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom,
                   RANK_W'($urandom)));
    issue(mk_row(CMD_READ, $urandom, 9'd0));
    issue(mk_row(CMD_READ, $urandom, 9'(DEPTH - 1)));
    repeat (12) issue(mk_row(CMD_READ, $urandom, RANK_W'($urandom_range(0, DEPTH - 1))));
    issue(mk_row(CMD_CLEAR, $urandom, RANK_W'($urandom)));
    issue(mk_row(CMD_READ, $urandom, 9'(DEPTH - 1)));
    while (work_items < RANDOM_ITEMS) run_episode();
    cmd_bus.valid <= 1'b0;

    // Drain the outstanding reads, then watch for stray results.
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending_reads.size() == 0 && sent_rows.size() == 0)
      $display("tb_descending_insertion_sorter: done, clean");
    else
      $display("tb_descending_insertion_sorter: done, errors");
    $finish;
  end

endmodule
